// ===== src/nsb_pkg.sv =====
`default_nettype none

package nsb_pkg;

    // width of every coordinate field on the ports
    localparam int FIELD_W = 16;

    // configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = CFG_ADDR_W - REG_IDX_LSB;

    localparam logic [REG_IDX_W-1:0] REG_SRC_BMP_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_BMP_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_BMP_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_BMP_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SRC_RECT       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DST_RECT       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_NEAREST = 3'd6;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } nsb_op_t;

    typedef enum logic [1:0] {
        ST_STARTED   = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_PIXEL     = 2'd2,
        ST_IDLE_STEP = 2'd3
    } nsb_status_t;

endpackage

`default_nettype wire

// ===== src/nsb_req_if.sv =====
`default_nettype none

interface nsb_req_if;
    logic                                 valid;
    logic                                 ready;
    nsb_pkg::nsb_op_t                     op;
    logic signed [nsb_pkg::FIELD_W-1:0]   clip_x;
    logic signed [nsb_pkg::FIELD_W-1:0]   clip_y;
    logic signed [nsb_pkg::FIELD_W-1:0]   clip_width;
    logic signed [nsb_pkg::FIELD_W-1:0]   clip_height;

    modport source (
        output valid, op, clip_x, clip_y, clip_width, clip_height,
        input  ready
    );

    modport sink (
        input  valid, op, clip_x, clip_y, clip_width, clip_height,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/nsb_rsp_if.sv =====
`default_nettype none

interface nsb_rsp_if;
    logic                          valid;
    logic                          ready;
    nsb_pkg::nsb_status_t          status;
    logic [nsb_pkg::FIELD_W-1:0]   dst_x;
    logic [nsb_pkg::FIELD_W-1:0]   dst_y;
    logic [nsb_pkg::FIELD_W-1:0]   src_x;
    logic [nsb_pkg::FIELD_W-1:0]   src_y;
    logic                          last;

    modport source (
        output valid, status, dst_x, dst_y, src_x, src_y, last,
        input  ready
    );

    modport sink (
        input  valid, status, dst_x, dst_y, src_x, src_y, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/nearest_stretch_blit_address_gen.sv =====
// Stretch-blit address generator with clipping and nearest-neighbor scaling.
// Channels: req (sink) takes words with op and a clip rectangle; rsp (source)
// gives one word per request: status, destination pixel, source pixel, last.
// Bitmap sizes, source and destination rectangles and the filter select are
// written over the APB port (register i at byte address 8*i, 64-bit data).
// A start runs the setup sequencer, one clip step per cycle: source check,
// escape check, bitmap clip, rectangle clip, intersection and area; a reject
// ends it early with ST_EMPTY, else it answers ST_STARTED. A step while idle
// answers with an idle-step status word. A step on an active blit runs two
// bit-serial lanes (x and y) in parallel: a shift-add multiply, then a
// restoring divide, and the pixel word waits until both lanes are done; when
// the destination size is not positive the lanes skip both and give the origin.
// One request is in flight at a time; req.ready is high only while idle.
// The finished word sits in an output register, so the next request is taken
// while rsp is stalled; its answer waits until that register is freed.
// Reset clears the blit state and rsp.valid and sets the registers to their
// defaults (filter_nearest to 1, all others to 0).
`default_nettype none

module nearest_stretch_blit_address_gen #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nsb_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [nsb_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [nsb_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready,
    nsb_req_if.sink                                  req,
    nsb_rsp_if.source                                rsp
);

    localparam int CW = COORD_BITS;
    localparam int FW = nsb_pkg::FIELD_W;
    localparam int WW = ((CW > 17) ? CW : 17) + 3;

    typedef logic signed [WW-1:0] wide_t;
    typedef logic signed [CW-1:0] crd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRC,
        S_ESC,
        S_BMP_FAR,
        S_BMP_NEAR,
        S_RECT_FAR,
        S_RECT_NEAR,
        S_ISECT,
        S_AREA,
        S_LAUNCH,
        S_WAIT,
        S_RESP
    } state_t;

    function automatic crd_t wrapc(input wide_t v);
        return v[CW-1:0];
    endfunction

    function automatic crd_t fld(input logic [FW-1:0] raw);
        return wrapc(wide_t'(signed'(raw)));
    endfunction

    // configuration registers
    logic [FW-1:0]                     sbw_reg;
    logic [FW-1:0]                     sbh_reg;
    logic [FW-1:0]                     dbw_reg;
    logic [FW-1:0]                     dbh_reg;
    logic [nsb_pkg::CFG_DATA_W-1:0]    src_rect_reg;
    logic [nsb_pkg::CFG_DATA_W-1:0]    dst_rect_reg;
    logic                              filt_reg;

    logic [nsb_pkg::REG_IDX_W-1:0]     cfg_idx;
    logic                              cfg_wr;

    assign cfg_idx = paddr[nsb_pkg::CFG_ADDR_W-1:nsb_pkg::REG_IDX_LSB];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbw_reg      <= '0;
            sbh_reg      <= '0;
            dbw_reg      <= '0;
            dbh_reg      <= '0;
            src_rect_reg <= '0;
            dst_rect_reg <= '0;
            filt_reg     <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                nsb_pkg::REG_SRC_BMP_WIDTH:  sbw_reg      <= pwdata[FW-1:0];
                nsb_pkg::REG_SRC_BMP_HEIGHT: sbh_reg      <= pwdata[FW-1:0];
                nsb_pkg::REG_DST_BMP_WIDTH:  dbw_reg      <= pwdata[FW-1:0];
                nsb_pkg::REG_DST_BMP_HEIGHT: dbh_reg      <= pwdata[FW-1:0];
                nsb_pkg::REG_SRC_RECT:       src_rect_reg <= pwdata;
                nsb_pkg::REG_DST_RECT:       dst_rect_reg <= pwdata;
                nsb_pkg::REG_FILTER_NEAREST: filt_reg     <= pwdata[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            nsb_pkg::REG_SRC_BMP_WIDTH:  prdata = nsb_pkg::CFG_DATA_W'(sbw_reg);
            nsb_pkg::REG_SRC_BMP_HEIGHT: prdata = nsb_pkg::CFG_DATA_W'(sbh_reg);
            nsb_pkg::REG_DST_BMP_WIDTH:  prdata = nsb_pkg::CFG_DATA_W'(dbw_reg);
            nsb_pkg::REG_DST_BMP_HEIGHT: prdata = nsb_pkg::CFG_DATA_W'(dbh_reg);
            nsb_pkg::REG_SRC_RECT:       prdata = src_rect_reg;
            nsb_pkg::REG_DST_RECT:       prdata = dst_rect_reg;
            nsb_pkg::REG_FILTER_NEAREST: prdata = nsb_pkg::CFG_DATA_W'(filt_reg);
            default:                     prdata = '0;
        endcase
    end

    // rectangle fields, wrapped to the coordinate width
    crd_t sx_f, sy_f, sw_f, sh_f, dx_f, dy_f, dw_f, dh_f;

    assign sx_f = fld(src_rect_reg[15:0]);
    assign sy_f = fld(src_rect_reg[31:16]);
    assign sw_f = fld(src_rect_reg[47:32]);
    assign sh_f = fld(src_rect_reg[63:48]);
    assign dx_f = fld(dst_rect_reg[15:0]);
    assign dy_f = fld(dst_rect_reg[31:16]);
    assign dw_f = fld(dst_rect_reg[47:32]);
    assign dh_f = fld(dst_rect_reg[63:48]);

    // sequencer and datapath registers
    state_t                 state_reg;
    crd_t                   cx_reg, cy_reg, cw_reg, ch_reg;
    crd_t                   sw_reg, sh_reg;
    wide_t                  l_reg, t_reg, r_reg, b_reg;
    wide_t                  px_reg, py_reg;
    crd_t                   area_l_reg, area_t_reg, area_w_reg, area_h_reg;
    crd_t                   eff_w_reg, eff_h_reg;
    logic [CW-1:0]          col_reg, row_reg;
    logic                   active_reg;
    nsb_pkg::nsb_status_t   res_status_reg;
    logic [FW-1:0]          res_dst_x_reg, res_dst_y_reg;
    logic                   res_last_reg;
    logic                   out_valid_reg;
    nsb_pkg::nsb_status_t   out_status_reg;
    logic [FW-1:0]          out_dst_x_reg, out_dst_y_reg;
    logic [FW-1:0]          out_src_x_reg, out_src_y_reg;
    logic                   out_last_reg;

    // full-precision views
    wide_t sxw, syw, sww, shw, dxw, dyw, dww, dhw;
    wide_t cxw, cyw, cww, chw;
    wide_t sbw_w, sbh_w, dbw_w, dbh_w;
    wide_t cx_end, cy_end, dx_end, dy_end;
    wide_t colw, roww, awm1, ahm1;
    wide_t off_x_w, off_y_w;

    assign sxw    = wide_t'(sx_f);
    assign syw    = wide_t'(sy_f);
    assign sww    = wide_t'(sw_f);
    assign shw    = wide_t'(sh_f);
    assign dxw    = wide_t'(dx_f);
    assign dyw    = wide_t'(dy_f);
    assign dww    = wide_t'(dw_f);
    assign dhw    = wide_t'(dh_f);
    assign cxw    = wide_t'(cx_reg);
    assign cyw    = wide_t'(cy_reg);
    assign cww    = wide_t'(cw_reg);
    assign chw    = wide_t'(ch_reg);
    assign sbw_w  = wide_t'(sbw_reg);
    assign sbh_w  = wide_t'(sbh_reg);
    assign dbw_w  = wide_t'(dbw_reg);
    assign dbh_w  = wide_t'(dbh_reg);
    assign cx_end = cxw + cww;
    assign cy_end = cyw + chw;
    assign dx_end = dxw + dww;
    assign dy_end = dyw + dhw;
    assign colw   = wide_t'(col_reg);
    assign roww   = wide_t'(row_reg);
    assign awm1   = wide_t'(area_w_reg) - wide_t'(1);
    assign ahm1   = wide_t'(area_h_reg) - wide_t'(1);
    assign off_x_w = px_reg - dxw;
    assign off_y_w = py_reg - dyw;

    crd_t   aw_n, ah_n;
    logic   src_reject, esc_fail, area_fail, setup_fail, fin;

    assign aw_n = wrapc(r_reg - l_reg);
    assign ah_n = wrapc(b_reg - t_reg);

    assign src_reject = (sxw >= sbw_w) || (syw >= sbh_w) || sxw[WW-1] || syw[WW-1];

    // right and bottom escapes test the bitmap width and height, not the rectangle size
    assign esc_fail = (dxw >= cx_end) || (dyw >= cy_end)
                   || (dxw + dbw_w - wide_t'(1) < cxw)
                   || (dyw + dbh_w - wide_t'(1) < cyw);

    assign area_fail = (r_reg <= l_reg) || (b_reg <= t_reg)
                    || aw_n[CW-1] || (aw_n == '0)
                    || ah_n[CW-1] || (ah_n == '0)
                    || !filt_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SRC:   setup_fail = src_reject;
            S_ESC:   setup_fail = esc_fail;
            S_AREA:  setup_fail = area_fail;
            default: setup_fail = 1'b0;
        endcase
    end

    assign fin = (colw >= awm1) && (roww >= ahm1);

    // scaling lanes
    logic signed [CW+1:0]   off_x, off_y;
    logic                   lane_start;
    logic                   busy_x, busy_y;
    logic [FW-1:0]          lane_x_res, lane_y_res;
    logic                   out_load;

    assign off_x      = off_x_w[CW+1:0];
    assign off_y      = off_y_w[CW+1:0];
    assign lane_start = (state_reg == S_LAUNCH);
    assign out_load   = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    nsb_scale #(
        .CW     (CW)
    ) u_scale_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lane_start),
        .off    (off_x),
        .ssize  (eff_w_reg),
        .dsize  (dw_f),
        .sorg   (sx_f),
        .busy   (busy_x),
        .result (lane_x_res)
    );

    nsb_scale #(
        .CW     (CW)
    ) u_scale_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lane_start),
        .off    (off_y),
        .ssize  (eff_h_reg),
        .dsize  (dh_f),
        .sorg   (sy_f),
        .busy   (busy_y),
        .result (lane_y_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            area_l_reg    <= '0;
            area_t_reg    <= '0;
            area_w_reg    <= '0;
            area_h_reg    <= '0;
            eff_w_reg     <= '0;
            eff_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cx_reg <= wrapc(wide_t'(req.clip_x));
                        cy_reg <= wrapc(wide_t'(req.clip_y));
                        cw_reg <= wrapc(wide_t'(req.clip_width));
                        ch_reg <= wrapc(wide_t'(req.clip_height));
                        if (req.op == nsb_pkg::OP_START)
                        begin
                            col_reg   <= '0;
                            row_reg   <= '0;
                            state_reg <= S_SRC;
                        end
                        else if (!active_reg)
                        begin
                            res_status_reg <= nsb_pkg::ST_IDLE_STEP;
                            res_dst_x_reg  <= '0;
                            res_dst_y_reg  <= '0;
                            res_last_reg   <= 1'b0;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            px_reg    <= wide_t'(area_l_reg) + colw;
                            py_reg    <= wide_t'(area_t_reg) + roww;
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                S_SRC:
                begin
                    sw_reg <= (sxw + sww > sbw_w) ? wrapc(sbw_w - sxw) : sw_f;
                    sh_reg <= (syw + shw > sbh_w) ? wrapc(sbh_w - syw) : sh_f;
                    if (src_reject)
                        state_reg <= S_RESP;
                    else
                        state_reg <= S_ESC;
                end
                S_ESC:
                begin
                    if (esc_fail)
                        state_reg <= S_RESP;
                    else
                        state_reg <= S_BMP_FAR;
                end
                S_BMP_FAR:
                begin
                    if (cx_end > dbw_w)
                        cw_reg <= wrapc(dbw_w - cxw);
                    if (cy_end > dbh_w)
                        ch_reg <= wrapc(dbh_w - cyw);
                    state_reg <= S_BMP_NEAR;
                end
                S_BMP_NEAR:
                begin
                    if (cxw[WW-1])
                    begin
                        cw_reg <= wrapc(cww + cxw);
                        cx_reg <= '0;
                    end
                    if (cyw[WW-1])
                    begin
                        ch_reg <= wrapc(chw + cyw);
                        cy_reg <= '0;
                    end
                    state_reg <= S_RECT_FAR;
                end
                S_RECT_FAR:
                begin
                    if (cx_end > dx_end)
                        cw_reg <= wrapc(dx_end - cxw);
                    if (cy_end > dy_end)
                        ch_reg <= wrapc(dy_end - cyw);
                    state_reg <= S_RECT_NEAR;
                end
                S_RECT_NEAR:
                begin
                    if (cxw <= dxw)
                    begin
                        cw_reg <= wrapc(cww - (dxw - cxw));
                        cx_reg <= dx_f;
                    end
                    if (cyw <= dyw)
                    begin
                        ch_reg <= wrapc(chw - (dyw - cyw));
                        cy_reg <= dy_f;
                    end
                    state_reg <= S_ISECT;
                end
                S_ISECT:
                begin
                    l_reg     <= (cxw > dxw) ? cxw : dxw;
                    t_reg     <= (cyw > dyw) ? cyw : dyw;
                    r_reg     <= (cx_end < dx_end) ? cx_end : dx_end;
                    b_reg     <= (cy_end < dy_end) ? cy_end : dy_end;
                    state_reg <= S_AREA;
                end
                S_AREA:
                begin
                    area_l_reg <= wrapc(l_reg);
                    area_t_reg <= wrapc(t_reg);
                    area_w_reg <= aw_n;
                    area_h_reg <= ah_n;
                    eff_w_reg  <= sw_reg;
                    eff_h_reg  <= sh_reg;
                    state_reg  <= S_RESP;
                end
                S_LAUNCH:
                begin
                    res_status_reg <= nsb_pkg::ST_PIXEL;
                    res_dst_x_reg  <= px_reg[FW-1:0];
                    res_dst_y_reg  <= py_reg[FW-1:0];
                    res_last_reg   <= fin;
                    if (fin)
                    begin
                        active_reg <= 1'b0;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    else if (colw >= awm1)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + CW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!busy_x && !busy_y)
                        state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_load)
                    begin
                        out_status_reg <= res_status_reg;
                        out_dst_x_reg  <= res_dst_x_reg;
                        out_dst_y_reg  <= res_dst_y_reg;
                        out_last_reg   <= res_last_reg;
                        if (res_status_reg == nsb_pkg::ST_PIXEL)
                        begin
                            out_src_x_reg <= lane_x_res;
                            out_src_y_reg <= lane_y_res;
                        end
                        else
                        begin
                            out_src_x_reg <= '0;
                            out_src_y_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;

            // setup ends early on a reject; the area step also decides success
            if (setup_fail)
            begin
                active_reg     <= 1'b0;
                res_status_reg <= nsb_pkg::ST_EMPTY;
                res_dst_x_reg  <= '0;
                res_dst_y_reg  <= '0;
                res_last_reg   <= 1'b0;
            end
            else if (state_reg == S_AREA)
            begin
                active_reg     <= 1'b1;
                res_status_reg <= nsb_pkg::ST_STARTED;
                res_dst_x_reg  <= '0;
                res_dst_y_reg  <= '0;
                res_last_reg   <= 1'b0;
            end
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.dst_x  = out_dst_x_reg;
    assign rsp.dst_y  = out_dst_y_reg;
    assign rsp.src_x  = out_src_x_reg;
    assign rsp.src_y  = out_src_y_reg;
    assign rsp.last   = out_last_reg;

    a_active_area: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (!area_w_reg[CW-1] && (area_w_reg != '0)
                        && !area_h_reg[CW-1] && (area_h_reg != '0)))
        else $error("active blit with empty area");

    a_walk_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((colw <= awm1) && (roww <= ahm1)))
        else $error("pixel walk left the clipped area");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != nsb_pkg::ST_PIXEL)) |->
            ((rsp.dst_x == '0) && (rsp.dst_y == '0) && (rsp.src_x == '0)
             && (rsp.src_y == '0) && !rsp.last))
        else $error("status word carries pixel fields");

    a_last_ends_blit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_status_reg == nsb_pkg::ST_PIXEL) && res_last_reg)
            |-> !active_reg)
        else $error("last pixel sent while blit still active");

    a_wait_after_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |->
            ($past(state_reg == S_LAUNCH) || $past(state_reg == S_WAIT)))
        else $error("lanes awaited without a launch");

endmodule

`default_nettype wire

// ===== src/nsb_scale.sv =====
`default_nettype none

// one source coordinate: (off * ssize) / dsize + sorg, truncating toward zero
// bit-serial shift-add multiply, then bit-serial restoring divide
module nsb_scale #(
    parameter int CW = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [CW+1:0]           off,
    input  wire logic signed [CW-1:0]           ssize,
    input  wire logic signed [CW-1:0]           dsize,
    input  wire logic signed [CW-1:0]           sorg,
    output logic                                busy,
    output logic [nsb_pkg::FIELD_W-1:0]         result
);

    localparam int OW   = CW + 2;
    localparam int PW   = OW + CW;
    localparam int CNTW = $clog2(PW);
    localparam int FW   = nsb_pkg::FIELD_W;
    localparam int XW   = (CW > FW) ? CW : FW;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } lane_state_t;

    lane_state_t        state_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [PW-1:0]      mcand_reg;
    logic [CW-1:0]      mplier_reg;
    logic [PW-1:0]      acc_reg;
    logic [CW-1:0]      rem_reg;
    logic [CW-1:0]      dsz_reg;
    logic               neg_reg;
    logic               byp_reg;
    logic [FW-1:0]      org_reg;
    logic [FW-1:0]      res_reg;

    logic [OW-1:0]      off_mag;
    logic [CW-1:0]      ss_mag;
    logic signed [XW-1:0] sorg_x;
    logic [CW-1:0]      shifted;
    logic               ge;
    logic [FW-1:0]      q16;
    logic [FW-1:0]      q16_signed;

    assign off_mag    = off[OW-1] ? OW'(-off) : OW'(off);
    assign ss_mag     = ssize[CW-1] ? CW'(-ssize) : CW'(ssize);
    assign sorg_x     = XW'(sorg);
    assign shifted    = {rem_reg[CW-2:0], acc_reg[PW-1]};
    assign ge         = (shifted >= dsz_reg);
    assign q16        = acc_reg[FW-1:0];
    assign q16_signed = neg_reg ? (~q16 + FW'(1)) : q16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        mcand_reg  <= PW'(off_mag);
                        mplier_reg <= ss_mag;
                        acc_reg    <= '0;
                        rem_reg    <= '0;
                        dsz_reg    <= dsize[CW-1:0];
                        neg_reg    <= off[OW-1] ^ ssize[CW-1];
                        byp_reg    <= dsize[CW-1] || (dsize == '0);
                        org_reg    <= sorg_x[FW-1:0];
                        cnt_reg    <= '0;
                        // a non-positive destination size gives the origin alone
                        if (dsize[CW-1] || (dsize == '0))
                            state_reg <= L_FIN;
                        else
                            state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[CW-1:1]};
                    if (cnt_reg == CNTW'(CW - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= L_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                L_DIV:
                begin
                    // quotient bits shift in where dividend bits leave
                    rem_reg <= ge ? (shifted - dsz_reg) : shifted;
                    acc_reg <= {acc_reg[PW-2:0], ge};
                    if (cnt_reg == CNTW'(PW - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= L_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                L_FIN:
                begin
                    res_reg   <= byp_reg ? org_reg : (q16_signed + org_reg);
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != L_IDLE);
    assign result = res_reg;

endmodule

`default_nettype wire
